FILE: sv/assert_macros.svh
// Assertion helpers. SYNTH builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// ante must be followed by cons in the same cycle
`define ASSERT_IMPLIES(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);
// cond must never be seen out of reset
`define ASSERT_NEVER(name, ck, rn, cond, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error(msg);
`else
`define ASSERT_IMPLIES(name, ck, rn, ante, cons, msg)
`define ASSERT_NEVER(name, ck, rn, cond, msg)
`endif

`endif

FILE: sv/hsv2rgb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hsv2rgb_pkg;

    localparam int FRAC_BITS_DEF = 12;

    localparam int HUE_W   = 16;
    localparam int SAT_W   = 14;
    localparam int VAL_W   = 14;
    localparam int MAG_W   = 14;   // magnitude of a 14-bit signed value, up to 8192
    localparam int LEVEL_W = 8;

    // color wheel sector, named by the edge it runs along
    typedef enum logic [2:0] {
        SECT_R_Y = 3'd0,
        SECT_Y_G = 3'd1,
        SECT_G_C = 3'd2,
        SECT_C_B = 3'd3,
        SECT_B_M = 3'd4,
        SECT_M_R = 3'd5
    } sector_t;

    typedef struct packed {
        logic    valid;
        sector_t sector;
    } ctrl_t;

endpackage

`default_nettype wire

FILE: sv/hsv2rgb_level.sv
`timescale 1ns / 1ps
`default_nettype none

// term * 255 >> SHIFT, truncated, clamped to 0..255; negative gives 0
module hsv2rgb_level #(
    parameter int TERM_W = 16,
    parameter int SHIFT  = 12
) (
    input  logic signed [TERM_W-1:0] term,
    output logic        [7:0]        level
);

    localparam int EXT_W  = (TERM_W > SHIFT + 2) ? TERM_W : SHIFT + 2;
    localparam int PROD_W = SHIFT + 9;

    logic [EXT_W-1:0]  mag;
    logic              big;
    logic [SHIFT:0]    low;
    logic [PROD_W-1:0] prod;
    logic [8:0]        quot;

    assign mag  = term[TERM_W-1] ? '0 : EXT_W'($unsigned(term));
    // anything at or above 2^(SHIFT+1) already maps past 255
    assign big  = |mag[EXT_W-1:SHIFT+1];
    assign low  = mag[SHIFT:0];
    assign prod = {low, 8'b0} - PROD_W'(low);
    assign quot = prod[PROD_W-1:SHIFT];

    assign level = (big || quot[8]) ? 8'hFF : quot[7:0];

endmodule

`default_nettype wire

FILE: sv/hsv2rgb_decode.sv
`timescale 1ns / 1ps
`default_nettype none

// stage 1: magnitudes, hue wrap, sector and fraction
module hsv2rgb_decode import hsv2rgb_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic signed [HUE_W-1:0]    hue,
    input  logic signed [SAT_W-1:0]    saturation,
    input  logic signed [VAL_W-1:0]    brightness,
    output ctrl_t                      ctrl,
    output logic        [MAG_W-1:0]    s_mag,
    output logic        [MAG_W-1:0]    v_mag,
    output logic        [FRAC_BITS-1:0] frac
);

    localparam int H6_W = FRAC_BITS + 3;
    localparam logic [FRAC_BITS-1:0] HALF_TURN = FRAC_BITS'(1) << (FRAC_BITS - 1);

    logic                 s_neg;
    logic [FRAC_BITS-1:0] h_wrap;
    logic [H6_W-1:0]      h6;

    ctrl_t                ctrl_reg, ctrl_next;
    logic [MAG_W-1:0]     s_reg, s_next;
    logic [MAG_W-1:0]     v_reg, v_next;
    logic [FRAC_BITS-1:0] f_reg, f_next;

    always_comb
    begin
        s_neg  = saturation[SAT_W-1];
        s_next = s_neg ? MAG_W'(-saturation) : MAG_W'(saturation);
        v_next = brightness[VAL_W-1] ? MAG_W'(-brightness) : MAG_W'(brightness);
        // negative saturation rotates hue by half a turn; wrap keeps the fraction only
        h_wrap = hue[FRAC_BITS-1:0] + (s_neg ? HALF_TURN : '0);
        h6     = (H6_W'(h_wrap) << 2) + (H6_W'(h_wrap) << 1);
        f_next = h6[FRAC_BITS-1:0];
        ctrl_next.valid  = in_valid;
        ctrl_next.sector = sector_t'(h6[H6_W-1:FRAC_BITS]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        v_reg <= v_next;
        f_reg <= f_next;
    end

    assign ctrl  = ctrl_reg;
    assign s_mag = s_reg;
    assign v_mag = v_reg;
    assign frac  = f_reg;

endmodule

`default_nettype wire

FILE: sv/hsv2rgb_terms.sv
`timescale 1ns / 1ps
`default_nettype none

// stages 2 and 3: S*F, S*(1-F), M = V*(1-S); then N and K = V*(1 - S*x)
module hsv2rgb_terms import hsv2rgb_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  ctrl_t                            ctrl_in,
    input  logic [MAG_W-1:0]                 s_mag,
    input  logic [MAG_W-1:0]                 v_mag,
    input  logic [FRAC_BITS-1:0]             frac,
    output ctrl_t                            ctrl_out,
    output logic [MAG_W+2*FRAC_BITS:0]       n_term,
    output logic [MAG_W+2*FRAC_BITS:0]       k_term,
    output logic [LEVEL_W-1:0]               m_level,
    output logic [LEVEL_W-1:0]               v_level
);

    localparam int SF_W  = MAG_W + FRAC_BITS;
    localparam int SK_W  = MAG_W + FRAC_BITS + 1;
    localparam int OMS_W = ((FRAC_BITS > MAG_W) ? FRAC_BITS : MAG_W) + 2;
    localparam int M_W   = OMS_W + MAG_W + 1;
    localparam int AP_W  = 2 * FRAC_BITS + 1;
    localparam int A_W   = ((AP_W > SK_W) ? AP_W : SK_W) + 1;
    localparam int N_W   = MAG_W + AP_W;
    localparam logic [FRAC_BITS:0] ONE   = (FRAC_BITS + 1)'(1) << FRAC_BITS;
    localparam logic [A_W-1:0]     ONE_SQ = A_W'(1) << (2 * FRAC_BITS);

    // stage 2
    logic [FRAC_BITS:0]       one_minus_f;
    logic signed [OMS_W-1:0]  one_minus_s;

    ctrl_t                    ctrl2_reg, ctrl2_next;
    logic [SF_W-1:0]          sf_reg, sf_next;
    logic [SK_W-1:0]          sk_reg, sk_next;
    logic signed [M_W-1:0]    m_reg, m_next;
    logic [MAG_W-1:0]         v2_reg;

    always_comb
    begin
        one_minus_f = ONE - {1'b0, frac};
        one_minus_s = $signed(OMS_W'(ONE)) - $signed(OMS_W'(s_mag));
        sf_next     = SF_W'(s_mag) * SF_W'(frac);
        sk_next     = SK_W'(s_mag) * SK_W'(one_minus_f);
        m_next      = $signed({1'b0, v_mag}) * one_minus_s;
        ctrl2_next  = ctrl_in;
    end

    // stage 3
    logic signed [A_W-1:0]    a_n, a_k;
    logic [AP_W-1:0]          an_pos, ak_pos;
    logic [LEVEL_W-1:0]       ml_comb, vl_comb;

    ctrl_t                    ctrl3_reg;
    logic [N_W-1:0]           n_reg, n_next;
    logic [N_W-1:0]           k_reg, k_next;
    logic [LEVEL_W-1:0]       ml_reg, vl_reg;

    always_comb
    begin
        a_n    = $signed(ONE_SQ) - $signed(A_W'(sf_reg));
        a_k    = $signed(ONE_SQ) - $signed(A_W'(sk_reg));
        // a non-positive factor gives a non-positive term, which levels to 0
        an_pos = a_n[A_W-1] ? '0 : a_n[AP_W-1:0];
        ak_pos = a_k[A_W-1] ? '0 : a_k[AP_W-1:0];
        n_next = N_W'(v2_reg) * N_W'(an_pos);
        k_next = N_W'(v2_reg) * N_W'(ak_pos);
    end

    hsv2rgb_level #(
        .TERM_W (M_W),
        .SHIFT  (2 * FRAC_BITS)
    ) u_m_level (
        .term  (m_reg),
        .level (ml_comb)
    );

    hsv2rgb_level #(
        .TERM_W (MAG_W + 1),
        .SHIFT  (FRAC_BITS)
    ) u_v_level (
        .term  ($signed({1'b0, v2_reg})),
        .level (vl_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl2_reg <= '0;
            ctrl3_reg <= '0;
        end
        else
        begin
            ctrl2_reg <= ctrl2_next;
            ctrl3_reg <= ctrl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sf_reg <= sf_next;
        sk_reg <= sk_next;
        m_reg  <= m_next;
        v2_reg <= v_mag;
        n_reg  <= n_next;
        k_reg  <= k_next;
        ml_reg <= ml_comb;
        vl_reg <= vl_comb;
    end

    assign ctrl_out = ctrl3_reg;
    assign n_term   = n_reg;
    assign k_term   = k_reg;
    assign m_level  = ml_reg;
    assign v_level  = vl_reg;

endmodule

`default_nettype wire

FILE: sv/hsv2rgb_route.sv
`timescale 1ns / 1ps
`default_nettype none

// stage 4: N and K levels, sector routing, output register
module hsv2rgb_route import hsv2rgb_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ctrl_t                      ctrl,
    input  logic [MAG_W+2*FRAC_BITS:0] n_term,
    input  logic [MAG_W+2*FRAC_BITS:0] k_term,
    input  logic [LEVEL_W-1:0]         m_level,
    input  logic [LEVEL_W-1:0]         v_level,
    output logic                       done,
    output logic [LEVEL_W-1:0]         red,
    output logic [LEVEL_W-1:0]         green,
    output logic [LEVEL_W-1:0]         blue
);

    localparam int N_W = MAG_W + 2 * FRAC_BITS + 1;

    logic [LEVEL_W-1:0] nl, kl;

    logic               done_reg, done_next;
    logic [LEVEL_W-1:0] r_reg, r_next;
    logic [LEVEL_W-1:0] g_reg, g_next;
    logic [LEVEL_W-1:0] b_reg, b_next;

    hsv2rgb_level #(
        .TERM_W (N_W + 1),
        .SHIFT  (3 * FRAC_BITS)
    ) u_n_level (
        .term  ($signed({1'b0, n_term})),
        .level (nl)
    );

    hsv2rgb_level #(
        .TERM_W (N_W + 1),
        .SHIFT  (3 * FRAC_BITS)
    ) u_k_level (
        .term  ($signed({1'b0, k_term})),
        .level (kl)
    );

    always_comb
    begin
        done_next = ctrl.valid;
        case (ctrl.sector)
            SECT_R_Y:
            begin
                r_next = v_level; g_next = kl;      b_next = m_level;
            end
            SECT_Y_G:
            begin
                r_next = nl;      g_next = v_level; b_next = m_level;
            end
            SECT_G_C:
            begin
                r_next = m_level; g_next = v_level; b_next = kl;
            end
            SECT_C_B:
            begin
                r_next = m_level; g_next = nl;      b_next = v_level;
            end
            SECT_B_M:
            begin
                r_next = kl;      g_next = m_level; b_next = v_level;
            end
            SECT_M_R:
            begin
                r_next = v_level; g_next = m_level; b_next = nl;
            end
            default:
            begin
                r_next = v_level; g_next = m_level; b_next = nl;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        g_reg <= g_next;
        b_reg <= b_next;
    end

    assign done  = done_reg;
    assign red   = r_reg;
    assign green = g_reg;
    assign blue  = b_reg;

endmodule

`default_nettype wire

FILE: sv/hsv_to_rgb_converter.sv
// HSV to RGB converter, one pixel per clock.
// Input word: hue, saturation and brightness in signed fixed point with
//   FRAC_BITS fraction bits; taken at a rising edge where start is high and
//   busy is low. busy is always low: the pipeline takes a word every cycle.
// Output word: red, green, blue (0..255), shown for exactly one cycle with
//   done high. The receiver cannot hold results off and needs none of that:
//   the pipeline never backs up.
// Path: decode, products, terms, level/route, in that order. Throughput:
//   1 word/cycle, set by the four register stages, each taking a new word
//   every cycle and holding at most one subtract ahead of one multiplier
//   rank.
// Reset (rst_n low, asynchronous) clears the valid bits of every stage; any
//   word in flight is dropped and done stays low until new words drain out.
// Words leave in the order they enter, one result per input word.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module hsv_to_rgb_converter import hsv2rgb_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic signed [HUE_W-1:0] hue,
    input  logic signed [SAT_W-1:0] saturation,
    input  logic signed [VAL_W-1:0] brightness,
    output logic                    done,
    output logic [LEVEL_W-1:0]      red,
    output logic [LEVEL_W-1:0]      green,
    output logic [LEVEL_W-1:0]      blue
);

    logic                       accept;

    // stage 1 -> stage 2
    ctrl_t                      ctrl_s1;
    logic [MAG_W-1:0]           s_mag;
    logic [MAG_W-1:0]           v_mag;
    logic [FRAC_BITS-1:0]       frac;

    // stage 3 -> stage 4
    ctrl_t                      ctrl_s3;
    logic [MAG_W+2*FRAC_BITS:0] n_term;
    logic [MAG_W+2*FRAC_BITS:0] k_term;
    logic [LEVEL_W-1:0]         m_level;
    logic [LEVEL_W-1:0]         v_level;

    // fully pipelined, never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // magnitudes, half-turn shift on negative saturation, hue*6 split
    hsv2rgb_decode #(
        .FRAC_BITS (FRAC_BITS)
    ) u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .ctrl       (ctrl_s1),
        .s_mag      (s_mag),
        .v_mag      (v_mag),
        .frac       (frac)
    );

    // exact products for M, N, K; M and V are leveled here too
    hsv2rgb_terms #(
        .FRAC_BITS (FRAC_BITS)
    ) u_terms (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl_in  (ctrl_s1),
        .s_mag    (s_mag),
        .v_mag    (v_mag),
        .frac     (frac),
        .ctrl_out (ctrl_s3),
        .n_term   (n_term),
        .k_term   (k_term),
        .m_level  (m_level),
        .v_level  (v_level)
    );

    // N/K leveling, per-sector channel select, output register
    hsv2rgb_route #(
        .FRAC_BITS (FRAC_BITS)
    ) u_route (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl_s3),
        .n_term  (n_term),
        .k_term  (k_term),
        .m_level (m_level),
        .v_level (v_level),
        .done    (done),
        .red     (red),
        .green   (green),
        .blue    (blue)
    );

    // every result traces back to a word taken through decode, products, terms and route
    `ASSERT_IMPLIES(a_done_has_source, clk, rst_n, done, $past(accept, 4), "done without a source word")

    // a word taken with reset high throughout comes out with done high
    `ASSERT_IMPLIES(a_no_drop, clk, rst_n, $past(accept && rst_n, 4) && $past(rst_n, 3) && $past(rst_n, 2) && $past(rst_n, 1), done, "accepted word lost")

    // zero brightness is black whatever hue and saturation are
    `ASSERT_IMPLIES(a_black, clk, rst_n, done && $past(accept && (brightness == '0), 4), (red == '0) && (green == '0) && (blue == '0), "zero brightness not black")

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the HSV to RGB converter.
// A short table of corner words runs first, then about 1350 random words.
// A behavioral model of the color math predicts every output word whose color is not typed in.
// Words go in at falling edges. Everything is sampled at rising edges.
module testbench;
    import hsv2rgb_pkg::*;

    localparam int FB         = FRAC_BITS_DEF;
    localparam int NUM_CORNER = 25;
    localparam int NUM_RANDOM = 1350;
    // pipeline is 4 deep; keep draining after the last result to catch stray strobes
    localparam int DRAIN_CYC  = 12;

    typedef struct packed {
        logic [LEVEL_W-1:0] r;
        logic [LEVEL_W-1:0] g;
        logic [LEVEL_W-1:0] b;
    } rgb_t;

    // one row of the corner table; known = 1 means the color is typed in
    typedef struct packed {
        logic signed [HUE_W-1:0] h;
        logic signed [SAT_W-1:0] s;
        logic signed [VAL_W-1:0] v;
        logic                    known;
        rgb_t                    color;
    } corner_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic signed [HUE_W-1:0] hue;
    logic signed [SAT_W-1:0] saturation;
    logic signed [VAL_W-1:0] brightness;
    logic                    done;
    logic [LEVEL_W-1:0]      red;
    logic [LEVEL_W-1:0]      green;
    logic [LEVEL_W-1:0]      blue;

    // typed color that rides along with the word on the input ports
    logic                    typed_valid;
    rgb_t                    typed_rgb;

    rgb_t pending_rgb[$];   // colors still owed by the pipeline, oldest first
    rgb_t want;

    int fail_count   = 0;
    int words_taken  = 0;
    int results_seen = 0;
    int neg_sat      = 0;
    int burst_left   = 0;

    hsv_to_rgb_converter #(.FRAC_BITS(FB)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .done       (done),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    // Corner table. Typed colors are the easy ones:
    //   s = 0 is grey at |v|*255 (clamped above one), v = 0 is black,
    //   pure hue 0 at s = v = 1 is red, a half turn is cyan,
    //   a negative saturation adds a half turn, hue wraps per turn.
    // Rows with known = 0 go through the model.
    corner_row_t corner_rows [NUM_CORNER] = '{
        '{16'sd0,      14'sd0,     14'sd0,      1'b1, '{8'd0,   8'd0,   8'd0}},
        '{16'sd0,      14'sd0,     14'sd4096,   1'b1, '{8'd255, 8'd255, 8'd255}},
        '{16'sd0,      14'sd0,     14'sd2048,   1'b1, '{8'd127, 8'd127, 8'd127}},
        '{16'sd0,      14'sd0,     14'sd8191,   1'b1, '{8'd255, 8'd255, 8'd255}},
        '{16'sd0,      14'sd0,     14'sh2000,   1'b1, '{8'd255, 8'd255, 8'd255}},
        '{16'sd0,      14'sd0,     -14'sd4096,  1'b1, '{8'd255, 8'd255, 8'd255}},
        '{16'sd0,      14'sd4096,  14'sd4096,   1'b1, '{8'd255, 8'd0,   8'd0}},
        '{16'sd4096,   14'sd4096,  14'sd4096,   1'b1, '{8'd255, 8'd0,   8'd0}},
        '{16'sd0,      -14'sd4096, 14'sd4096,   1'b1, '{8'd0,   8'd255, 8'd255}},
        '{16'sh8000,   14'sd4096,  14'sd4096,   1'b1, '{8'd255, 8'd0,   8'd0}},
        '{16'sd32767,  14'sd4096,  14'sd4096,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'sd683,    14'sd4096,  14'sd4096,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'sd1365,   14'sd4096,  14'sd4096,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'sd2048,   14'sd4096,  14'sd4096,   1'b1, '{8'd0,   8'd255, 8'd255}},
        '{16'sd2731,   14'sd4096,  14'sd4096,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'sd3413,   14'sd4096,  14'sd4096,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'sd4095,   14'sd4096,  14'sd4096,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'sd0,      14'sd8191,  14'sd4096,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'sd0,      14'sh2000,  14'sd4096,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'sd1000,   14'sd6000,  14'sd8191,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'sd3000,   -14'sd1,    -14'sd1,     1'b0, '{8'd0,   8'd0,   8'd0}},
        '{-16'sd1,     14'sd2048,  -14'sd2048,  1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'sd12345,  14'sd8191,  14'sd8191,   1'b0, '{8'd0,   8'd0,   8'd0}},
        '{16'sd0,      14'sd4096,  14'sd0,      1'b1, '{8'd0,   8'd0,   8'd0}},
        '{16'sd2048,   -14'sd4096, 14'sd4096,   1'b1, '{8'd255, 8'd0,   8'd0}}
    };

    // term*255 scaled down by k fraction widths, truncated, clamped to 0..255
    function automatic logic [LEVEL_W-1:0] level_of(input longint term, input int k);
        longint q;
        if (term <= 0)
            return '0;
        q = (term * 255) >>> (k * FB);
        if (q > 255)
            q = 255;
        return q[LEVEL_W-1:0];
    endfunction

    // Expected color for one word: fold saturation sign into a half turn,
    // take magnitudes, wrap hue, split into sector and fraction, route terms.
    function automatic rgb_t hsv_to_levels(input logic signed [HUE_W-1:0] h_in,
                                           input logic signed [SAT_W-1:0] s_in,
                                           input logic signed [VAL_W-1:0] v_in);
        logic [HUE_W:0] h;
        logic [31:0]    h6;
        longint         s;
        longint         v;
        longint         f;
        longint         one;
        sector_t        sect;
        logic [LEVEL_W-1:0] vl;
        logic [LEVEL_W-1:0] ml;
        logic [LEVEL_W-1:0] nl;
        logic [LEVEL_W-1:0] kl;
        rgb_t           res;
        one = longint'(1) << FB;
        h   = {1'b0, h_in};
        s   = longint'(s_in);
        v   = longint'(v_in);
        if (s < 0)
        begin
            h = h + (HUE_W + 1)'(1 << (FB - 1));
            s = -s;
        end
        if (v < 0)
            v = -v;
        h6   = 32'(h[FB-1:0]) * 6;
        sect = sector_t'(h6[FB+2:FB]);
        f    = longint'(h6[FB-1:0]);
        vl = level_of(v, 1);
        ml = level_of(v * (one - s), 2);
        nl = level_of(v * (one * one - s * f), 3);
        kl = level_of(v * (one * one - s * (one - f)), 3);
        case (sect)
            SECT_R_Y: res = '{vl, kl, ml};
            SECT_Y_G: res = '{nl, vl, ml};
            SECT_G_C: res = '{ml, vl, kl};
            SECT_C_B: res = '{ml, nl, vl};
            SECT_B_M: res = '{kl, ml, vl};
            default:  res = '{vl, ml, nl};
        endcase
        return res;
    endfunction

    // Saturation or value: mostly inside -1..1, with the 14-bit extremes,
    // exact one and zero, near-one values and full-range noise mixed in.
    function automatic logic signed [SAT_W-1:0] pick_q12();
        int m;
        case ($urandom_range(0, 9))
            0, 1:    m = int'($urandom_range(0, 16383)) - 8192;
            2:       m = 0;
            3:       m = $urandom_range(0, 1) ? 4096 : -4096;
            4:       m = ($urandom_range(0, 1) ? 4096 : -4096) + int'($urandom_range(0, 6)) - 3;
            5:       m = $urandom_range(0, 1) ? 8191 : -8192;
            default: m = int'($urandom_range(0, 8192)) - 4096;
        endcase
        return SAT_W'(m);
    endfunction

    // Hue: mostly any 16-bit value, sometimes just around a sector boundary
    // in a random turn, so the sector split is hit at its edges.
    function automatic logic signed [HUE_W-1:0] pick_hue();
        int k;
        int base;
        if ($urandom_range(0, 3) != 0)
            return HUE_W'($urandom);
        k    = $urandom_range(0, 6);
        base = (k * 4096 + 3) / 6;
        return HUE_W'(base + int'($urandom_range(0, 6)) - 3 + int'($urandom_range(0, 15)) * 4096);
    endfunction

    // Idle cycles before the next word: runs of back-to-back words,
    // otherwise mostly short gaps and now and then a long one.
    function automatic int idle_len();
        int p;
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        p = $urandom_range(0, 99);
        if (p < 5)
        begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (p < 45)
            return 0;
        if (p < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Put one word on the inputs at a falling edge and hold it until taken.
    task automatic send_word(input logic signed [HUE_W-1:0] h,
                             input logic signed [SAT_W-1:0] s,
                             input logic signed [VAL_W-1:0] v,
                             input logic                    known,
                             input rgb_t                    color,
                             input int                      gap);
        @(negedge clk);
        if (gap > 0)
        begin
            start       = 1'b0;
            typed_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start       = 1'b1;
        hue         = h;
        saturation  = s;
        brightness  = v;
        typed_valid = known;
        typed_rgb   = color;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Scoreboard. Both halves look at pre-edge values on the rising edge.
    // A strobe is checked against the oldest owed color; a taken word
    // pushes its color (typed or predicted) onto the back.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_rgb.size() == 0)
                begin
                    $error("unexpected result: red %0d green %0d blue %0d", red, green, blue);
                    fail_count++;
                end
                else
                begin
                    want = pending_rgb.pop_front();
                    results_seen++;
                    if (red !== want.r)
                    begin
                        $error("red: expected %0d, got %0d", want.r, red);
                        fail_count++;
                    end
                    if (green !== want.g)
                    begin
                        $error("green: expected %0d, got %0d", want.g, green);
                        fail_count++;
                    end
                    if (blue !== want.b)
                    begin
                        $error("blue: expected %0d, got %0d", want.b, blue);
                        fail_count++;
                    end
                end
            end
            if (start && !busy)
            begin
                pending_rgb.push_back(typed_valid ? typed_rgb
                                                  : hsv_to_levels(hue, saturation, brightness));
                words_taken++;
                if (saturation < 0)
                    neg_sat++;
            end
        end
    end

    // Stimulus: reset, corner table, random words, then drain and report.
    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        hue         = '0;
        saturation  = '0;
        brightness  = '0;
        typed_valid = 1'b0;
        typed_rgb   = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (corner_rows[i])
            send_word(corner_rows[i].h, corner_rows[i].s, corner_rows[i].v,
                      corner_rows[i].known, corner_rows[i].color, $urandom_range(0, 2));

        for (int n = 0; n < NUM_RANDOM; n++)
            send_word(pick_hue(), pick_q12(), pick_q12(), 1'b0, '0, idle_len());

        @(negedge clk);
        start       = 1'b0;
        typed_valid = 1'b0;

        // the timeout block covers a pipeline that never empties
        while (pending_rgb.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);

        $display("covered %0d words (%0d from the corner table), %0d with negative saturation",
                 words_taken, NUM_CORNER, neg_sat);
        $display("compared %0d results, %0d mismatches", results_seen, fail_count);
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Hard stop: far beyond the slowest legal run (every word after a long gap).
    initial
    begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending_rgb.size());
        $display("testbench: FAIL");
        $finish;
    end

endmodule
